// ===== rtl/spq_pkg.sv =====
package spq_pkg;

   // Command codes carried on the request word.
   typedef enum logic [1:0] {
      CMD_PUSH    = 2'd0,
      CMD_POP     = 2'd1,
      CMD_DISPLAY = 2'd2,
      CMD_SIZE    = 2'd3
   } command_type;

   // Status codes carried on the response word.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // Operation applied to every cell of the chain at once.
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_PUSH   = 2'd1,
      CELL_POP    = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_op_type;

   typedef struct packed {
      command_type        command;
      logic signed [31:0] item_value;
      logic signed [15:0] priority_req;
   } req_word_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] out_item;
      logic signed [15:0] out_priority;
      logic [4:0]         count;
      logic               last;
   } rsp_word_type;

   // One stored queue entry.
   typedef struct packed {
      logic signed [31:0] item;
      logic signed [15:0] prio;
   } entry_type;

   // Broadcast control shared by all cells.
   typedef struct packed {
      cell_op_type op;
      entry_type   fresh;
      entry_type   head;
   } cell_ctrl_type;

endpackage

// ===== rtl/spq_cell.sv =====
module spq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  spq_pkg::entry_type    left_entry,
   input  logic                  left_before,
   input  logic                  left_valid,
   input  spq_pkg::entry_type    right_entry,
   input  logic                  right_valid,
   output spq_pkg::entry_type    entry,
   output logic                  valid,
   output logic                  ahead
);
   import spq_pkg::*;

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;

   // The new entry belongs ahead of this cell's entry. Ties go behind, so
   // equal priorities keep their arrival order.
   assign ahead = !valid_ff || ($signed(ctrl.fresh.prio) < $signed(entry_ff.prio));

   // Next cell contents for the broadcast operation.
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      unique case (ctrl.op)
         CELL_PUSH: begin
            if (ahead) begin
               // An empty cell past the tail fills only when it is the insertion
               // point or its left neighbor hands over a held entry.
               valid_in = valid_ff || left_valid || !left_before;
               entry_in = left_before ? left_entry : ctrl.fresh;
            end
         end
         CELL_POP: begin
            entry_in = right_entry;
            valid_in = right_valid;
         end
         CELL_ROTATE: begin
            // The last occupied cell takes the old head, the rest shift forward.
            if (valid_ff) begin
               entry_in = right_valid ? right_entry : ctrl.head;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Channel  Direction  Ports                          Word
// request  in         req_valid, req_stall, req_word command, item, priority
// response out        rsp_valid, rsp_stall, rsp_word status, item, priority, count, last
//
// Push and pop shift the chain of cells in a single step; size leaves it as it is.
// Display gives one word per stored entry; the chain rotates once per word.
// The output register is the only stage between the chain and the response side.
// Reset clears the count, the display state, the cell valid bits and the output valid; no sweep.
// The request side is held while a response word is stalled or a display runs.
module sorted_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  spq_pkg::req_word_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output spq_pkg::rsp_word_type rsp_word
);
   import spq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic          disp_ff, disp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_word_ff, rsp_word_in;
   cell_ctrl_type ctrl;

   entry_type cell_ent [CAPACITY];
   logic      cell_val [CAPACITY];
   logic      cell_bef [CAPACITY];
   entry_type left_ent [CAPACITY];
   logic      left_bef [CAPACITY];
   logic      left_val [CAPACITY];
   entry_type right_ent [CAPACITY];
   logic      right_val [CAPACITY];

   logic req_fire, out_free, full, empty;

   // Handshake on both channels.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = disp_ff || !out_free;
   assign req_fire  = req_valid && !req_stall;
   assign full      = (cnt_ff == CW'(CAPACITY));
   assign empty     = (cnt_ff == '0);

   // Command decode, chain control and response word.
   always_comb begin
      cnt_in          = cnt_ff;
      rem_in          = rem_ff;
      disp_in         = disp_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_word_in     = rsp_word_ff;
      ctrl.op         = CELL_HOLD;
      ctrl.fresh.item = req_word.item_value;
      ctrl.fresh.prio = req_word.priority_req;
      ctrl.head       = cell_ent[0];

      if (disp_ff && out_free) begin
         // Next display word comes from the head, then the chain rotates.
         ctrl.op                  = CELL_ROTATE;
         rsp_valid_in             = 1'b1;
         rsp_word_in.status       = ST_OK;
         rsp_word_in.out_item     = cell_ent[0].item;
         rsp_word_in.out_priority = cell_ent[0].prio;
         rsp_word_in.count        = 5'(cnt_ff);
         rsp_word_in.last         = (rem_ff == CW'(1));
         rem_in                   = rem_ff - CW'(1);
         disp_in                  = (rem_ff != CW'(1));
      end else if (req_fire) begin
         rsp_valid_in             = 1'b1;
         rsp_word_in.status       = ST_OK;
         rsp_word_in.out_item     = '0;
         rsp_word_in.out_priority = '0;
         rsp_word_in.last         = 1'b1;
         unique case (req_word.command)
            CMD_PUSH: begin
               if (full) begin
                  rsp_word_in.status = ST_FULL;
               end else begin
                  ctrl.op = CELL_PUSH;
                  cnt_in  = cnt_ff + CW'(1);
               end
            end
            CMD_POP: begin
               if (empty) begin
                  rsp_word_in.status = ST_UNDERFLOW;
               end else begin
                  ctrl.op                  = CELL_POP;
                  cnt_in                   = cnt_ff - CW'(1);
                  rsp_word_in.out_item     = cell_ent[0].item;
                  rsp_word_in.out_priority = cell_ent[0].prio;
               end
            end
            CMD_DISPLAY: begin
               if (empty) begin
                  rsp_word_in.status = ST_EMPTY;
               end else begin
                  ctrl.op                  = CELL_ROTATE;
                  rsp_word_in.out_item     = cell_ent[0].item;
                  rsp_word_in.out_priority = cell_ent[0].prio;
                  rsp_word_in.last         = (cnt_ff == CW'(1));
                  rem_in                   = cnt_ff - CW'(1);
                  disp_in                  = (cnt_ff != CW'(1));
               end
            end
            default: begin
            end
         endcase
         rsp_word_in.count = 5'(cnt_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rem_ff       <= '0;
         disp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rem_ff       <= rem_in;
         disp_ff      <= disp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Chain of cells, head at index zero.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_ent[i] = '0;
         assign left_bef[i] = 1'b0;
         assign left_val[i] = 1'b0;
      end else begin : g_mid
         assign left_ent[i] = cell_ent[i-1];
         assign left_bef[i] = cell_bef[i-1];
         assign left_val[i] = cell_val[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_ent[i] = '0;
         assign right_val[i] = 1'b0;
      end else begin : g_body
         assign right_ent[i] = cell_ent[i+1];
         assign right_val[i] = cell_val[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (left_ent[i]),
         .left_before (left_bef[i]),
         .left_valid  (left_val[i]),
         .right_entry (right_ent[i]),
         .right_valid (right_val[i]),
         .entry       (cell_ent[i]),
         .valid       (cell_val[i]),
         .ahead       (cell_bef[i])
      );
   end

endmodule
